>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Synthesis flows define SYNTH, and then every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// When a holds at a clock edge, b must hold at that same edge.
`define HBRGB_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: implication does not hold");

// The expression a must never be true at a clock edge.
`define HBRGB_ASSERT_NEVER(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
		else $error("assertion failed: forbidden condition seen");

`else

`define HBRGB_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define HBRGB_ASSERT_NEVER(label, clk, rst_n, a)

`endif

`endif

>>> rtl/hbrgb_pkg.sv
package hbrgb_pkg;

	// Full level of one 8-bit color channel.
	localparam int unsigned FullLevelC  = 255;
	localparam int unsigned WhiteEndC   = 2 * FullLevelC;
	localparam int unsigned WheelSpanC  = 6 * FullLevelC;
	localparam int unsigned ColorBitsC  = 8;
	localparam int unsigned QueueDepthC = 4;
	localparam logic [15:0] PeriodResetC = 16'hFFFF;

	typedef logic [7:0] lvl_t;

	typedef enum logic [1:0] {
		SHADE_DARK,
		SHADE_WHITE,
		SHADE_FULL
	} shade_mode_t;

	typedef struct packed {
		logic [15:0] hue;
		logic [15:0] brightness;
	} cmd_t;

	typedef struct packed {
		logic [15:0] red_compare;
		logic [15:0] green_compare;
		logic [15:0] blue_compare;
		logic        red_update;
		logic        green_update;
		logic        blue_update;
	} res_t;

	// Classified item handed from the front to the back. Index 2 is red,
	// 1 is green, 0 is blue.
	typedef struct packed {
		shade_mode_t mode;
		lvl_t        factor;
		lvl_t [2:0]  level;
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic afull;
	} queue_stat_t;

	// Exact x / 255 for x up to 255 * 255.
	function automatic lvl_t div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

>>> rtl/hbrgb_front.sv
module hbrgb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  hbrgb_pkg::cmd_t    command,
	output logic               push,
	output hbrgb_pkg::cls_t    item
);
	import hbrgb_pkg::*;

	logic        valid_s1;
	cls_t        item_s1;
	cls_t        cls;
	logic [15:0] d;

	always_comb begin
		cls = '0;
		d   = 16'd0;
		if (command.hue < 16'(FullLevelC)) begin
			cls.level = {8'hFF, command.hue[7:0], 8'h00};
		end else if (command.hue < 16'(2 * FullLevelC)) begin
			d = command.hue - 16'(FullLevelC);
			cls.level = {8'hFF - d[7:0], 8'hFF, 8'h00};
		end else if (command.hue < 16'(3 * FullLevelC)) begin
			d = command.hue - 16'(2 * FullLevelC);
			cls.level = {8'h00, 8'hFF, d[7:0]};
		end else if (command.hue < 16'(4 * FullLevelC)) begin
			d = command.hue - 16'(3 * FullLevelC);
			cls.level = {8'h00, 8'hFF - d[7:0], 8'hFF};
		end else if (command.hue < 16'(5 * FullLevelC)) begin
			d = command.hue - 16'(4 * FullLevelC);
			cls.level = {d[7:0], 8'h00, 8'hFF};
		end else if (command.hue < 16'(WheelSpanC)) begin
			d = command.hue - 16'(5 * FullLevelC);
			cls.level = {8'hFF, 8'h00, 8'hFF - d[7:0]};
		end else begin
			cls.level = {8'hFF, 8'h00, 8'h01};
		end

		if (command.brightness < 16'(FullLevelC)) begin
			cls.mode   = SHADE_DARK;
			cls.factor = command.brightness[7:0];
		end else if (command.brightness <= 16'(WhiteEndC)) begin
			cls.mode   = SHADE_WHITE;
			cls.factor = 8'(command.brightness - 16'(FullLevelC));
		end else begin
			cls.mode   = SHADE_FULL;
			cls.factor = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= cls;
		end
	end

	assign push = valid_s1;
	assign item = item_s1;

endmodule

>>> rtl/hbrgb_queue.sv
module hbrgb_queue #(
	parameter int unsigned Depth = hbrgb_pkg::QueueDepthC
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hbrgb_pkg::cls_t       wr_item,
	input  logic                  pop,
	output hbrgb_pkg::cls_t       rd_item,
	output hbrgb_pkg::queue_stat_t stat
);
	import hbrgb_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	cls_t            entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign do_push = push && (count_q != CntW'(Depth));
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	assign rd_item    = entries_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CntW'(Depth));
	assign stat.afull = (count_q >= CntW'(Depth - 1));

endmodule

>>> rtl/hbrgb_back.sv
module hbrgb_back #(
	parameter int unsigned ColorBits = hbrgb_pkg::ColorBitsC
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	input  hbrgb_pkg::cls_t  item,
	input  logic [15:0]      period,
	output logic             done,
	output hbrgb_pkg::res_t  result
);
	import hbrgb_pkg::*;

	logic [2:0][15:0] prod_s2;
	lvl_t [2:0]       level_s2;
	shade_mode_t      mode_s2;
	logic             valid_s2;

	lvl_t [2:0]       level_s3;
	logic             valid_s3;

	res_t             result_s4;
	logic             valid_s4;

	logic [2:0][15:0] prod;
	lvl_t [2:0]       shaded;
	logic [2:0][15:0] cmp;
	logic [2:0]       upd;

	// Blend product: the channel level toward black, its headroom toward white.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (item.mode == SHADE_WHITE) begin
				prod[c] = 16'(8'hFF - item.level[c]) * 16'(item.factor);
			end else begin
				prod[c] = 16'(item.level[c]) * 16'(item.factor);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			case (mode_s2)
				SHADE_DARK:  shaded[c] = div255(prod_s2[c]);
				SHADE_WHITE: shaded[c] = div255(prod_s2[c]) + level_s2[c];
				SHADE_FULL:  shaded[c] = 8'hFF;
				default:     shaded[c] = 8'hFF;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [23:0] full_prod;
			logic [23:0] scaled;
			full_prod = 24'(period) * 24'(level_s3[c]);
			scaled    = full_prod >> ColorBits;
			upd[c]    = ((16'(level_s3[c]) >> ColorBits) == 16'd0);
			cmp[c]    = upd[c] ? scaled[15:0] : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2  <= prod;
		level_s2 <= item.level;
		mode_s2  <= item.mode;
		level_s3 <= shaded;
		result_s4.red_compare   <= cmp[2];
		result_s4.green_compare <= cmp[1];
		result_s4.blue_compare  <= cmp[0];
		result_s4.red_update    <= upd[2];
		result_s4.green_update  <= upd[1];
		result_s4.blue_update   <= upd[0];
	end

	assign done   = valid_s4;
	assign result = result_s4;

endmodule

>>> rtl/hue_brightness_to_rgb_pwm_unit.sv
// Channel     Handshake              Payload            Direction
// command     start / busy           hbrgb_pkg::cmd_t   in
// result      done (one-cycle)       hbrgb_pkg::res_t   out
// config      cfg_we                 cfg_wdata (period) in
//
// One transaction is accepted per cycle while busy is low. On its way to the
// result it passes five registers in order: the front register, the queue slot
// and the three back stages (blend multiply, divide by 255, period multiply).
// Reset clears the valid bits, the queue and sets the period to 65535.
// The receiver cannot stall, so the back drains the queue every cycle and
// busy only rises if the queue ever comes within one entry of full.
`include "assert_macros.svh"

module hue_brightness_to_rgb_pwm_unit #(
	parameter int unsigned ColorBits  = hbrgb_pkg::ColorBitsC,
	parameter int unsigned QueueDepth = hbrgb_pkg::QueueDepthC
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  hbrgb_pkg::cmd_t command,
	output logic            done,
	output hbrgb_pkg::res_t result,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata
);
	import hbrgb_pkg::*;

	logic [15:0] period_q;
	logic        push;
	cls_t        front_item;
	cls_t        back_item;
	queue_stat_t q_stat;
	logic        back_valid;

	// The period register. The user writes it only while the block is idle; the
	// block does not enforce this. The back reads it directly, no shadow copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PeriodResetC;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// Room is kept for the transaction still sitting in the front register.
	assign busy = q_stat.afull;

	// The front decodes the hue sector and sorts the brightness into a blend
	// mode, then hands the classified transaction to the queue.
	hbrgb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.push    (push),
		.item    (front_item)
	);

	hbrgb_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (back_valid),
		.rd_item (back_item),
		.stat    (q_stat)
	);

	// The back never stalls, so it pops whenever the queue holds anything.
	assign back_valid = !q_stat.empty;

	hbrgb_back #(
		.ColorBits (ColorBits)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (back_valid),
		.item   (back_item),
		.period (period_q),
		.done   (done),
		.result (result)
	);

	// A push into a full queue would drop a transaction.
	`HBRGB_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && q_stat.full)
	// Every result traces back to an accepted transaction.
	`HBRGB_ASSERT_IMPLIES(a_done_has_cmd, clk, arst_n, done, $past(start && !busy, 5))
	// Since the back drains every cycle, the queue never backs up far enough
	// to hold off the sender.
	`HBRGB_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)

endmodule

>>> tb/testbench.sv
`default_nettype none

// Regression for the hue and brightness to RGB PWM unit.
//
// A directed table walks the corners of the color wheel and of the brightness
// ranges. A few rows carry hand-written results; the rest are checked against
// a color predictor kept in this file. After the table come several random
// phases. Each phase first programs a new PWM period while the block is idle,
// then sends transactions with its own pattern of sender gaps.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hbrgb_pkg::*;

	// The full-white compare value at the reset period: (65535 * 255) >> 8.
	localparam logic [15:0] WhiteCmpC = 16'd65279;
	// The compare value of a level of 1 at the reset period.
	localparam logic [15:0] LevelOneCmpC = 16'd255;
	localparam int unsigned CycleLimitC = 200000;
	// This leaves margin over the result's trip through the pipeline.
	localparam int unsigned DrainCyclesC = 12;
	localparam int unsigned PhaseItemsC = 200;
	localparam int unsigned NumPhasesC = 5;

	typedef struct {
		cmd_t cmd;
		logic has_ref;
		res_t ref_res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        command = '0;
	logic        done;
	res_t        result;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// A hand-written result travels alongside the command, so the monitor can
	// pick it up on the very edge that accepts the transaction.
	logic row_has_ref = 1'b0;
	res_t row_ref_res = '0;

	// The period the predictor assumes; only changed while the block is idle.
	logic [15:0] period_setting = PeriodResetC;

	res_t expected_colors[$];
	int unsigned cycle_count = 0;
	int unsigned sent_count = 0;
	int unsigned checked_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned stray_count = 0;
	int unsigned period_writes = 0;

	stim_row_t directed_rows[$];

	hue_brightness_to_rgb_pwm_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Toward black below full level, toward white up to twice full level,
	// plain white beyond that.
	function automatic int unsigned blend_level(input int unsigned lvl, input int unsigned br);
		if (br < FullLevelC) begin
			return (lvl * br) / FullLevelC;
		end
		if (br <= WhiteEndC) begin
			return ((FullLevelC - lvl) * (br - FullLevelC)) / FullLevelC + lvl;
		end
		return FullLevelC;
	endfunction

	// Levels that do not fit in the compare resolution give no update.
	function automatic logic [16:0] level_to_compare(input int unsigned lvl,
			input logic [15:0] period);
		int unsigned prod;
		if (lvl >= (32'd1 << ColorBitsC)) begin
			return 17'd0;
		end
		prod = (int'(period) * lvl) >> ColorBitsC;
		return {prod[15:0], 1'b1};
	endfunction

	function automatic res_t predict_color(input cmd_t c, input logic [15:0] period);
		int unsigned h;
		int unsigned br;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		logic [16:0] rc;
		logic [16:0] gc;
		logic [16:0] bc;
		res_t o;
		h = c.hue;
		br = c.brightness;
		if (h < FullLevelC) begin
			r = FullLevelC; g = h; b = 0;
		end else if (h < 2 * FullLevelC) begin
			r = 2 * FullLevelC - h; g = FullLevelC; b = 0;
		end else if (h < 3 * FullLevelC) begin
			r = 0; g = FullLevelC; b = h - 2 * FullLevelC;
		end else if (h < 4 * FullLevelC) begin
			r = 0; g = 4 * FullLevelC - h; b = FullLevelC;
		end else if (h < 5 * FullLevelC) begin
			r = h - 4 * FullLevelC; g = 0; b = FullLevelC;
		end else if (h < WheelSpanC) begin
			r = FullLevelC; g = 0; b = WheelSpanC - h;
		end else begin
			// Past the end of the wheel the color sticks at a near-pure red.
			r = FullLevelC; g = 0; b = 1;
		end
		rc = level_to_compare(blend_level(r, br), period);
		gc = level_to_compare(blend_level(g, br), period);
		bc = level_to_compare(blend_level(b, br), period);
		o.red_compare = rc[16:1];
		o.green_compare = gc[16:1];
		o.blue_compare = bc[16:1];
		o.red_update = rc[0];
		o.green_update = gc[0];
		o.blue_update = bc[0];
		return o;
	endfunction

	function automatic stim_row_t make_row(input int unsigned h, input int unsigned br,
			input logic has_ref, input logic [15:0] rcmp, input logic [15:0] gcmp,
			input logic [15:0] bcmp);
		stim_row_t s;
		s.cmd.hue = h[15:0];
		s.cmd.brightness = br[15:0];
		s.has_ref = has_ref;
		s.ref_res = {rcmp, gcmp, bcmp, 3'b111};
		return s;
	endfunction

	// Presents one transaction and holds it until the block takes it. Called
	// right after a rising edge, so every drive lands as one NBA in that step.
	task automatic send_color(input cmd_t c, input logic has_ref, input res_t ref_res);
		start <= 1'b1;
		command <= c;
		row_has_ref <= has_ref;
		row_ref_res <= ref_res;
		do begin
			@(posedge clk);
		end while (busy);
		sent_count++;
	endtask

	task automatic idle_cycle();
		start <= 1'b0;
		row_has_ref <= 1'b0;
		@(posedge clk);
	endtask

	// Holds the sender back until every result in flight has been checked.
	task automatic drain_results();
		start <= 1'b0;
		row_has_ref <= 1'b0;
		@(posedge clk);
		while (expected_colors.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// The block must be idle here; the predictor follows the new period at once.
	task automatic write_period(input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		period_setting = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		period_writes++;
	endtask

	// Acceptance and checking live in one process: the expectation for a
	// transaction is queued on its accepting edge, and every result strobe
	// takes the oldest expectation. Both read values from before the edge.
	always @(posedge clk) begin
		res_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (start && !busy) begin
				if (row_has_ref) begin
					expected_colors.push_back(row_ref_res);
				end else begin
					expected_colors.push_back(predict_color(command, period_setting));
				end
			end
			if (done) begin
				if (expected_colors.size() == 0) begin
					stray_count++;
					if (stray_count + mismatch_count <= 10) begin
						$display("[%0t] result with nothing outstanding: %h", $realtime, result);
					end
				end else begin
					want = expected_colors.pop_front();
					checked_count++;
					if (result !== want) begin
						mismatch_count++;
						if (stray_count + mismatch_count <= 10) begin
							$display("[%0t] mismatch: expected r=%0d g=%0d b=%0d upd=%b%b%b",
								$realtime, want.red_compare, want.green_compare,
								want.blue_compare, want.red_update, want.green_update,
								want.blue_update);
							$display("[%0t]           actual   r=%0d g=%0d b=%0d upd=%b%b%b",
								$realtime, result.red_compare, result.green_compare,
								result.blue_compare, result.red_update, result.green_update,
								result.blue_update);
						end
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		if (cycle_count >= CycleLimitC) begin
			$display("hue_brightness_to_rgb_pwm_unit regression: fail");
			$finish;
		end
	end

	initial begin
		cmd_t c;
		int unsigned idle_pct;
		logic [15:0] period_plan[NumPhasesC];
		int unsigned idle_plan[NumPhasesC];

		// Rows with a typed result use the reset period of 65535. The corners of
		// each wheel sector and of the blend ranges go through the predictor.
		directed_rows.push_back(make_row(0, 0, 1'b1, 16'd0, 16'd0, 16'd0));
		directed_rows.push_back(make_row(0, 511, 1'b1, WhiteCmpC, WhiteCmpC, WhiteCmpC));
		directed_rows.push_back(make_row(65535, 65535, 1'b1, WhiteCmpC, WhiteCmpC, WhiteCmpC));
		directed_rows.push_back(make_row(1530, 255, 1'b1, WhiteCmpC, 16'd0, LevelOneCmpC));
		directed_rows.push_back(make_row(65535, 255, 1'b1, WhiteCmpC, 16'd0, LevelOneCmpC));
		directed_rows.push_back(make_row(0, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(254, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(255, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(509, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(510, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(764, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(765, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(1019, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(1020, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(1274, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(1275, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(1529, 255, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(100, 254, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(100, 1, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(300, 256, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(800, 510, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(1200, 400, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(1529, 510, 1'b0, '0, '0, '0));
		directed_rows.push_back(make_row(65535, 254, 1'b0, '0, '0, '0));

		// Each random phase gets a period, extremes included, and a sender gap
		// rate. Zero gaps give long back-to-back stretches.
		period_plan[0] = 16'd1;
		period_plan[1] = 16'd0;
		period_plan[2] = 16'($urandom_range(2, 65534));
		period_plan[3] = 16'hFFFF;
		period_plan[4] = 16'd32768;
		idle_plan[0] = 0;
		idle_plan[1] = 74;
		idle_plan[2] = 26;
		idle_plan[3] = 0;
		idle_plan[4] = 74;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_color(directed_rows[i].cmd, directed_rows[i].has_ref,
				directed_rows[i].ref_res);
		end

		for (int p = 0; p < NumPhasesC; p++) begin
			drain_results();
			write_period(period_plan[p]);
			idle_pct = idle_plan[p];
			for (int n = 0; n < PhaseItemsC; n++) begin
				// Mostly hues on the wheel and brightness in the blend ranges, where
				// the arithmetic is; the rest sweeps every bit of both fields.
				case ($urandom_range(0, 9))
					0, 1: begin
						c.hue = 16'($urandom);
						c.brightness = 16'($urandom);
					end
					2: begin
						c.hue = 16'($urandom_range(0, 5) * FullLevelC + $urandom_range(0, 1));
						c.brightness = 16'($urandom_range(0, 1) ? $urandom_range(253, 257)
							: $urandom_range(508, 512));
					end
					default: begin
						c.hue = 16'($urandom_range(0, WheelSpanC - 1));
						c.brightness = 16'($urandom_range(0, WhiteEndC));
					end
				endcase
				while ($urandom_range(1, 100) <= idle_pct) begin
					idle_cycle();
				end
				send_color(c, 1'b0, '0);
				// Once in the middle, let the pipeline empty out completely.
				if (p == 2 && n == PhaseItemsC / 2) begin
					drain_results();
				end
			end
		end

		drain_results();
		// Anything that still trickles out now has no expectation and fails.
		repeat (DrainCyclesC) @(posedge clk);

		$display("Sent %0d transactions (%0d directed) over %0d period settings;",
			sent_count, directed_rows.size(), period_writes + 1);
		$display("checked %0d results, %0d mismatches, %0d unexpected results.",
			checked_count, mismatch_count, stray_count);
		if (mismatch_count == 0 && stray_count == 0 && expected_colors.size() == 0) begin
			$display("hue_brightness_to_rgb_pwm_unit regression: pass");
		end else begin
			$display("hue_brightness_to_rgb_pwm_unit regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> hue_brightness_to_rgb_pwm_unit.f
+incdir+rtl
rtl/hbrgb_pkg.sv
rtl/hbrgb_front.sv
rtl/hbrgb_queue.sv
rtl/hbrgb_back.sv
rtl/hue_brightness_to_rgb_pwm_unit.sv
tb/testbench.sv
